// ===== rtl/lzss_pkg.sv =====
// ============================================================================
// lzss_pkg
// Shared constants, beat types and control interface types for the LZSS
// token stream decoder.
// ============================================================================
`timescale 1ns / 1ps

package lzss_pkg;

  // History window and copy limits
  localparam int WINDOW   = 4096;
  localparam int MAX_COPY = 64;
  localparam int AW       = $clog2(WINDOW);        // history address width
  localparam int CW       = $clog2(WINDOW + 1);    // output count width
  localparam int LW       = $clog2(MAX_COPY + 1);  // copy length counter width

  // Flag byte codes
  localparam logic [7:0] FLAG_COPY    = 8'h00;
  localparam logic [7:0] FLAG_LITERAL = 8'h01;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       bad_reference;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic lit_push;   // store and emit the literal byte
    logic ld_off_hi;  // capture offset high byte
    logic ld_off_lo;  // assemble offset
    logic ld_len_hi;  // capture length high byte
    logic ld_len;     // load copy length counter
    logic err_out;    // emit the error beat
    logic rd;         // issue history read for next copy byte
    logic cp_push;    // store and emit one copied byte
    logic clr;        // return stream position to start
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic bad;        // current copy token is illegal
    logic last;       // copy counter at its final byte
  } dp_stat_t;

endpackage

// ===== rtl/lzss_ctrl.sv =====
// ============================================================================
// lzss_ctrl
// Token parser and copy sequencer; drives datapath commands.
// ============================================================================
`timescale 1ns / 1ps

module lzss_ctrl import lzss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_beat,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {ST_PARSE, ST_RD, ST_WR} state_t;
  typedef enum logic [2:0] {
    PH_FLAG, PH_LIT, PH_OFF_HI, PH_OFF_LO, PH_LEN_HI, PH_LEN_LO
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   end_pend, end_pend_next;
  logic   emit_phase;
  logic   accept;

  // Phases that produce a beat need room in the output register
  assign emit_phase = (phase == PH_LIT) || (phase == PH_LEN_LO);
  assign in_stall   = !((state == ST_PARSE) && (!emit_phase || stat.out_free));
  assign accept     = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    end_pend_next = end_pend;
    cmd           = '0;
    case (state)
      ST_PARSE: begin
        if (accept) begin
          case (phase)
            PH_FLAG: begin
              if (in_beat.in_byte == FLAG_LITERAL) begin
                phase_next = PH_LIT;
              end else if (in_beat.in_byte == FLAG_COPY) begin
                phase_next = PH_OFF_HI;
              end
            end
            PH_LIT: begin
              cmd.lit_push = 1'b1;
              phase_next   = PH_FLAG;
            end
            PH_OFF_HI: begin
              cmd.ld_off_hi = 1'b1;
              phase_next    = PH_OFF_LO;
            end
            PH_OFF_LO: begin
              cmd.ld_off_lo = 1'b1;
              phase_next    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              cmd.ld_len_hi = 1'b1;
              phase_next    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              phase_next = PH_FLAG;
              if (stat.bad) begin
                cmd.err_out = 1'b1;
              end else begin
                cmd.ld_len    = 1'b1;
                end_pend_next = in_beat.stream_end;
                state_next    = ST_RD;
              end
            end
            default: phase_next = PH_FLAG;
          endcase
          // Stream end takes effect now unless a copy still runs
          if (in_beat.stream_end) begin
            phase_next = PH_FLAG;
            if (state_next == ST_PARSE) begin
              cmd.clr = 1'b1;
            end
          end
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        if (stat.out_free) begin
          cmd.cp_push = 1'b1;
          if (stat.last) begin
            cmd.clr    = end_pend;
            state_next = ST_PARSE;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      default: state_next = ST_PARSE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_PARSE;
      phase    <= PH_FLAG;
      end_pend <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      end_pend <= end_pend_next;
    end
  end

`ifndef SYNTHESIS
  // Input is only taken while parsing
  a_accept_parse: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == ST_PARSE)
    else $error("input accepted during copy");

  // A pending output beat is never overwritten
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.lit_push || cmd.cp_push || cmd.err_out) |-> stat.out_free)
    else $error("output beat overwritten");

  // Copy write step always follows a read step
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |-> ($past(state) == ST_RD || $past(state) == ST_WR))
    else $error("copy write without read");

  // Copy starts only from a legal token
  a_copy_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_len |-> !stat.bad)
    else $error("illegal copy started");
`endif

endmodule

// ===== rtl/lzss_dp.sv =====
// ============================================================================
// lzss_dp
// History window, token holds, stream position and output register.
// ============================================================================
`timescale 1ns / 1ps

module lzss_dp import lzss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  in_beat_t   in_beat,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_beat
);

  localparam logic [15:0] WINDOW16 = 16'(WINDOW);
  localparam logic [15:0] MAXCP16  = 16'(MAX_COPY);
  localparam logic [16:0] WINDOW17 = 17'(WINDOW);

  logic [7:0]    first_fill;
  logic [7:0]    off_hi;
  logic [15:0]   off;
  logic [7:0]    len_hi;
  logic [LW-1:0] remain;
  logic [AW-1:0] wp, wp_inc;
  logic [CW-1:0] count;
  logic [7:0]    rdata;
  logic          fill_sel;
  logic [7:0]    hist [WINDOW];

  logic [15:0]   len_word;
  logic [16:0]   src_wide;
  logic [AW-1:0] src;
  logic          push;
  logic [7:0]    push_val;

  // Token checks and source address
  assign len_word = {len_hi, in_beat.in_byte};
  assign stat.bad = (off == 16'd0) || (off > WINDOW16) ||
                    (len_word == 16'd0) || (len_word > MAXCP16);
  assign src_wide = ({{(17-AW){1'b0}}, wp} >= {1'b0, off}) ?
                    ({{(17-AW){1'b0}}, wp} - {1'b0, off}) :
                    ({{(17-AW){1'b0}}, wp} + WINDOW17 - {1'b0, off});
  assign src      = src_wide[AW-1:0];
  assign wp_inc   = (wp == AW'(WINDOW - 1)) ? '0 : wp + 1'b1;

  assign push     = cmd.lit_push || cmd.cp_push;
  assign push_val = cmd.lit_push ? in_beat.in_byte : (fill_sel ? first_fill : rdata);

  assign stat.out_free = !out_valid || !out_stall;
  assign stat.last     = (remain == LW'(1));

  // History memory
  always_ff @(posedge clk) begin
    if (push) begin
      hist[wp] <= push_val;
    end
    if (cmd.rd) begin
      rdata <= hist[src];
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_fill <= 8'd0;
    end else if (cfg_we) begin
      first_fill <= cfg_wdata;
    end
  end

  // Token holds, copy counter and fill select
  always_ff @(posedge clk) begin
    if (rst) begin
      off_hi <= 8'd0;
      off    <= 16'd0;
      len_hi <= 8'd0;
      remain <= '0;
    end else begin
      if (cmd.ld_off_hi) off_hi <= in_beat.in_byte;
      if (cmd.ld_off_lo) off    <= {off_hi, in_beat.in_byte};
      if (cmd.ld_len_hi) len_hi <= in_beat.in_byte;
      if (cmd.ld_len) begin
        remain <= len_word[LW-1:0];
      end else if (cmd.cp_push) begin
        remain <= remain - 1'b1;
      end
      if (cmd.clr) begin
        off_hi <= 8'd0;
        off    <= 16'd0;
        len_hi <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      fill_sel <= off > 16'(count);
    end
  end

  // Stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      count <= '0;
    end else if (cmd.clr) begin
      wp    <= '0;
      count <= '0;
    end else if (push) begin
      wp <= wp_inc;
      if (count != CW'(WINDOW)) begin
        count <= count + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push || cmd.err_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_out) begin
      out_beat <= '{out_byte: 8'd0, run_last: 1'b1, bad_reference: 1'b1};
    end else if (push) begin
      out_beat <= '{out_byte: push_val, run_last: cmd.lit_push || stat.last,
                    bad_reference: 1'b0};
    end
  end

endmodule

// ===== rtl/lzss_token_stream_decoder.sv =====
// ============================================================================
// lzss_token_stream_decoder
// LZSS token stream decoder: flag/literal and flag/offset/length tokens in,
// decoded bytes out, with a 4096-byte history window.
// ============================================================================
// Usage:
//   in channel: one encoded byte per beat (in_valid/in_stall), stream_end
//   marks the last byte of a stream. out channel: one decoded byte or one
//   error beat per beat (out_valid/out_stall); run_last marks the final beat
//   caused by an input byte. cfg_we/cfg_wdata write the fill byte used for
//   copies that reach before the first byte of the stream; write it only
//   while the block is idle.
// Timing:
//   A literal or an error beat appears in the cycle after its byte is accepted.
//   A copy token is handled one byte at a time (history read, then write and
//   emit per byte); input is stalled until the last copied byte is in the
//   output register.
//   The single-port history RAM with registered read sets the copy rate.
// Reset: parser, position and fill byte clear; no memory pass.
// Stall: a held output beat blocks only bytes that would emit a new beat.
// ============================================================================
`timescale 1ns / 1ps

module lzss_token_stream_decoder import lzss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_beat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_beat
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Parser and copy sequencer
  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .stat     (stat),
    .cmd      (cmd)
  );

  // History, holds and output register
  lzss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

// ===== verif/tb_lzss_token_stream_decoder.sv =====
// ============================================================================
// tb_lzss_token_stream_decoder
// Self-checking testbench for the LZSS token stream decoder. Encoded bytes
// are queued by the stimulus thread and sent by a clocked driver. Each
// accepted beat runs through an in-bench decoder that queues the expected
// output beats. The monitor checks each output beat against the oldest one.
// Stimulus covers literals, overlapping and before-start copies, rejected
// copies, skipped flags, cut-off tokens and a stream long enough to wrap the
// history window. Sender and receiver idle at random.
// ============================================================================
`timescale 1ns / 1ps

module tb_lzss_token_stream_decoder;
  import lzss_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 2 * MAX_COPY + 20;  // cycles for in-flight copy work

  typedef enum logic [2:0] {
    P_FLAG, P_LIT, P_OFF_HI, P_OFF_LO, P_LEN_HI, P_LEN_LO
  } parse_phase_e;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  lzss_token_stream_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  in_beat_t  encoded_bytes[$];
  out_beat_t expected_beats[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_send = 1'b0;
  int        planned_len = 0;  // rough decoded length of the open stream

  // Decoder state mirror
  parse_phase_e     phase;
  logic [7:0]       off_hi_q;
  logic [15:0]      offset_q;
  logic [7:0]       len_hi_q;
  logic [7:0]       history [WINDOW];
  logic [CW-1:0]    out_count;
  logic [AW-1:0]    wr_pos;
  logic [7:0]       fill_byte = 8'h00;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void restart_stream();
    phase     = P_FLAG;
    off_hi_q  = '0;
    offset_q  = '0;
    len_hi_q  = '0;
    out_count = '0;
    wr_pos    = '0;
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    history[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
    if (out_count < WINDOW) out_count = out_count + 1'b1;
  endfunction

  // Decode one accepted byte and queue the beats it causes
  function automatic void decode_byte(input in_beat_t beat);
    logic [15:0]   len;
    logic [7:0]    v;
    logic [AW-1:0] src;
    case (phase)
      P_FLAG: begin
        if (beat.in_byte == FLAG_LITERAL) phase = P_LIT;
        else if (beat.in_byte == FLAG_COPY) phase = P_OFF_HI;
      end
      P_LIT: begin
        store_byte(beat.in_byte);
        expected_beats.push_back('{beat.in_byte, 1'b1, 1'b0});
        phase = P_FLAG;
      end
      P_OFF_HI: begin
        off_hi_q = beat.in_byte;
        phase = P_OFF_LO;
      end
      P_OFF_LO: begin
        offset_q = {off_hi_q, beat.in_byte};
        phase = P_LEN_HI;
      end
      P_LEN_HI: begin
        len_hi_q = beat.in_byte;
        phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        len = {len_hi_q, beat.in_byte};
        if (offset_q == 0 || offset_q > WINDOW || len == 0 || len > MAX_COPY) begin
          expected_beats.push_back('{8'h00, 1'b1, 1'b1});
        end else begin
          for (int i = 0; i < len; i++) begin
            // source slot wraps in the window; offset WINDOW lands on wr_pos
            if (offset_q > out_count) begin
              v = fill_byte;
            end else begin
              src = wr_pos - offset_q[AW-1:0];
              v = history[src];
            end
            store_byte(v);
            expected_beats.push_back('{v, (i == len - 1), 1'b0});
          end
        end
        phase = P_FLAG;
      end
      default: phase = P_FLAG;
    endcase
    if (beat.stream_end) restart_stream();
  endfunction

  // Input driver: one nonblocking update of valid and payload per edge
  always @(posedge clk) begin : drive_in
    logic     nxt_valid;
    in_beat_t nxt_beat;
    if (rst) begin
      restart_stream();
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_beat  = in_beat;
      if (in_valid && !in_stall) begin
        decode_byte(in_beat);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && !hold_send && encoded_bytes.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_beat  = encoded_bytes.pop_front();
      end
      in_valid <= nxt_valid;
      in_beat  <= nxt_beat;
    end
  end

  // Output monitor and receiver stall
  always @(posedge clk) begin : watch_out
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", out_beat));
      end else begin
        want = expected_beats.pop_front();
        if (out_beat.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h",
                                    out_beat.out_byte, want.out_byte));
        if (out_beat.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b",
                                    out_beat.run_last, want.run_last));
        if (out_beat.bad_reference !== want.bad_reference)
          report_mismatch($sformatf("bad_reference %b, want %b",
                                    out_beat.bad_reference, want.bad_reference));
      end
    end
    out_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus helpers
  task automatic put(input logic [7:0] b, input bit e);
    encoded_bytes.push_back('{b, e});
    if (e) planned_len = 0;
  endtask

  task automatic put_literal(input logic [7:0] b, input bit e);
    planned_len++;
    put(FLAG_LITERAL, 1'b0);
    put(b, e);
  endtask

  task automatic put_copy(input int off, input int len, input bit e);
    if (off != 0 && off <= WINDOW && len != 0 && len <= MAX_COPY) planned_len += len;
    put(FLAG_COPY, 1'b0);
    put(off[15:8], 1'b0);
    put(off[7:0], 1'b0);
    put(len[15:8], 1'b0);
    put(len[7:0], e);
  endtask

  // Random tokens; long_run builds one stream past the window size
  task automatic random_tokens(input int n_items, input int end_pct, input bit long_run);
    int sent;
    int r;
    int r2;
    int off;
    int len;
    int k;
    bit e;
    sent = 0;
    while (long_run ? (planned_len < WINDOW + 320) : (sent < n_items)) begin
      e = !long_run && ($urandom_range(99) < end_pct);
      r = $urandom_range(99);
      if (long_run) r = (r < 10) ? 0 : 40;
      if (r < 28) begin
        put_literal(8'($urandom_range(255)), e);
        sent += 2;
      end else if (r < 78) begin
        r2 = $urandom_range(9);
        if (long_run) len = MAX_COPY;
        else if (r2 < 6) len = $urandom_range(1, 8);
        else if (r2 < 9) len = $urandom_range(9, MAX_COPY - 1);
        else len = MAX_COPY;
        r2 = $urandom_range(9);
        if (r2 < 7)
          off = $urandom_range(1, (planned_len == 0) ? 4 :
                                  (planned_len > WINDOW) ? WINDOW : planned_len);
        else if (r2 < 9) off = $urandom_range(1, WINDOW);
        else off = WINDOW;
        put_copy(off, len, e);
        sent += 5;
      end else if (r < 88) begin
        // rejected copy token
        off = $urandom_range(1, WINDOW);
        len = $urandom_range(1, MAX_COPY);
        case ($urandom_range(3))
          0: off = 0;
          1: off = $urandom_range(WINDOW + 1, 'hFFFF);
          2: len = 0;
          default: len = $urandom_range(MAX_COPY + 1, 'hFFFF);
        endcase
        put_copy(off, len, e);
        sent += 5;
      end else if (r < 94) begin
        // skipped flag byte
        put(8'($urandom_range(2, 255)), e);
      end else begin
        // copy token cut off by the end of its stream
        k = $urandom_range(1, 4);
        put(FLAG_COPY, k == 1);
        for (int j = 2; j <= k; j++) put(8'($urandom_range(255)), j == k);
        sent += k;
      end
    end
  endtask

  // Wait until every queued byte is accepted and every beat has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (encoded_bytes.size() != 0 || in_valid || expected_beats.size() != 0);
  endtask

  task automatic write_fill(input logic [7:0] v);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fill_byte = v;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 24;
    recv_idle_pct = 47;
    write_fill(8'h5A);

    // Directed tokens
    put_literal(8'h00, 1'b0);
    put_literal(8'hFF, 1'b0);
    put(8'h7E, 1'b0);               // skipped flag
    put_copy(1, 3, 1'b0);           // overlapping copy repeats one byte
    put_copy('h100, 2, 1'b0);       // reaches before stream start: fill byte
    put_copy(WINDOW + 1, MAX_COPY, 1'b0);  // offset beyond window: rejected
    put(FLAG_COPY, 1'b0);           // token cut off by stream end
    put(8'h00, 1'b0);
    put(8'h02, 1'b0);
    put(8'h00, 1'b1);

    // Sender holds back until all beats are out
    write_fill(8'h00);
    random_tokens(40, 8, 1'b0);

    write_fill(8'hFF);
    send_idle_pct = 47;
    recv_idle_pct = 24;
    random_tokens(20, 8, 1'b0);
    do @(negedge clk);
    while (encoded_bytes.size() != 0);
    hold_send = 1'b1;
    do @(negedge clk);
    while (in_valid || expected_beats.size() != 0);
    hold_send = 1'b0;
    random_tokens(20, 8, 1'b0);

    // No idling: one long stream wraps the window, then short streams
    write_fill(8'($urandom_range(1, 254)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    put_literal(8'($urandom_range(255)), 1'b1);
    random_tokens(0, 0, 1'b1);
    put_literal(8'($urandom_range(255)), 1'b1);
    random_tokens(20, 10, 1'b0);

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
